// File: design/encoding_index_line_parser_top_macros.svh
// Assertion macros for the encoding index line parser.
// Included by the top level; depends on nothing else.
`ifndef ENCODING_INDEX_LINE_PARSER_TOP_MACROS_SVH
`define ENCODING_INDEX_LINE_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define EILP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define EILP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/eilp_pkg.sv
// Package for the encoding index line parser: widths, character codes,
// parse states, status codes and the hex digit decoder. No dependencies.
package eilp_pkg;

    localparam int POINTER_BITS   = 8;
    localparam int CODEPOINT_BITS = 21;

    // Fixed widths of the result fields.
    localparam int POINTER_OUT_BITS   = 8;
    localparam int CODEPOINT_OUT_BITS = 21;
    localparam int STATUS_BITS        = 4;
    localparam int M_TDATA_BITS       = 40;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_X     = 8'h78;

    typedef enum logic [2:0] {
        PS_LINE_START   = 3'd0,
        PS_IGNORE       = 3'd1,
        PS_BEFORE_INDEX = 3'd2,
        PS_POINTER      = 3'd3,
        PS_BEFORE_CP    = 3'd4,
        PS_CODEPOINT    = 3'd5
    } parse_state_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_PARSING      = 4'd0,
        STAT_DONE         = 4'd1,
        STAT_BAD_START    = 4'd2,
        STAT_BAD_BEFORE_I = 4'd3,
        STAT_BAD_POINTER  = 4'd4,
        STAT_BAD_BEFORE_C = 4'd5,
        STAT_BAD_CP       = 4'd6,
        STAT_MALFORMED    = 4'd7,
        STAT_OVERFLOW     = 4'd8
    } status_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b == CHAR_TAB);
    endfunction

    function automatic logic is_dec(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t d;
        d.valid = 1'b1;
        d.value = b[3:0];
        if (is_dec(b)) begin
            d.value = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            // 'a'..'f' and 'A'..'F' have low nibbles 1..6.
            d.value = b[3:0] + 4'd9;
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

// File: design/encoding_index_line_parser_top.sv
// Top level of the encoding index line parser: byte parser state and result register.
// Depends on eilp_pkg and encoding_index_line_parser_top_macros.svh.
//
// Usage: the text of a single-byte encoding index enters one byte per beat on the
// s_ channel (s_tdata[7:0] holds the byte, s_tlast marks end of input with the byte
// ignored). Every input beat produces exactly one result beat on the m_ channel:
// m_tuser says a pointer/codepoint pair completed on that byte, m_tdata carries the
// pair and the sticky status. m_tvalid rises in the cycle after the accept.
// Throughput is one byte per cycle unless stalled: the parse state update is one pass
// of logic from the state registers into the result register, so beats may follow
// back to back. When the receiver stalls, the result register holds its beat and s_tready
// drops until that beat is taken; a new byte is accepted in the same cycle the held
// result leaves. Reset clears the parser to line start with status parsing and
// empties the result register. Once the status becomes nonzero it sticks: every
// later byte and end mark reports the same status and no entry, until reset.
`include "encoding_index_line_parser_top_macros.svh"

module encoding_index_line_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [eilp_pkg::M_TDATA_BITS-1:0] m_tdata,
    // [7:0] pointer, [28:8] codepoint, [32:29] status, [39:33] zero
    output logic        m_tuser    // entry_valid
);

    localparam int PB  = eilp_pkg::POINTER_BITS;
    localparam int CB  = eilp_pkg::CODEPOINT_BITS;
    localparam int PBX = PB + 4;
    localparam int POB = eilp_pkg::POINTER_OUT_BITS;
    localparam int COB = eilp_pkg::CODEPOINT_OUT_BITS;
    localparam int PW_EXT = (PB > POB) ? PB : POB;
    localparam int CW_EXT = (CB > COB) ? CB : COB;
    localparam int PAD_BITS = eilp_pkg::M_TDATA_BITS - POB - COB - eilp_pkg::STATUS_BITS;

    eilp_pkg::parse_state_t state_reg, state_next, exam_state;
    eilp_pkg::status_t      status_reg, status_next;
    logic [PB-1:0]          ptr_reg, ptr_next;
    logic [CB-1:0]          cp_reg, cp_next;
    logic                   seen_reg, seen_next;
    logic                   entry_next;
    logic                   examine;

    logic                   m_valid_reg;
    logic                   m_entry_reg;
    logic [POB-1:0]         m_ptr_reg, m_ptr_next;
    logic [COB-1:0]         m_cp_reg, m_cp_next;
    eilp_pkg::status_t      m_status_reg;

    logic                   accept;
    logic [7:0]             b;
    logic [PBX-1:0]         ptr_wide, ptr_sum;
    logic                   ptr_ovf, cp_ovf;
    eilp_pkg::hex_digit_t   hex;
    logic [PW_EXT-1:0]      ptr_ext;
    logic [CW_EXT-1:0]      cp_ext;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    // Decimal accumulate as shift-and-add; the top four bits flag overflow.
    assign ptr_wide = PBX'(ptr_reg);
    assign ptr_sum  = (ptr_wide << 3) + (ptr_wide << 1) + PBX'(b[3:0]);
    assign ptr_ovf  = |ptr_sum[PBX-1:PB];
    assign hex      = eilp_pkg::hex_decode(b);
    assign cp_ovf   = |cp_reg[CB-1:CB-4];

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        ptr_next    = ptr_reg;
        cp_next     = cp_reg;
        seen_next   = seen_reg;
        entry_next  = 1'b0;
        examine     = 1'b0;
        exam_state  = state_reg;
        if (status_reg == eilp_pkg::STAT_PARSING) begin
            if (s_tlast) begin
                status_next = (state_reg == eilp_pkg::PS_LINE_START) ?
                              eilp_pkg::STAT_DONE : eilp_pkg::STAT_MALFORMED;
            end else begin
                unique case (state_reg)
                    eilp_pkg::PS_POINTER: begin
                        if (eilp_pkg::is_dec(b)) begin
                            ptr_next  = ptr_sum[PB-1:0];
                            seen_next = 1'b1;
                            if (ptr_ovf) begin
                                status_next = eilp_pkg::STAT_OVERFLOW;
                            end
                        end else if (!seen_reg) begin
                            status_next = eilp_pkg::STAT_BAD_POINTER;
                        end else begin
                            state_next = eilp_pkg::PS_BEFORE_CP;
                            exam_state = eilp_pkg::PS_BEFORE_CP;
                            examine    = 1'b1;
                        end
                    end
                    eilp_pkg::PS_CODEPOINT: begin
                        if (hex.valid) begin
                            cp_next   = {cp_reg[CB-5:0], hex.value};
                            seen_next = 1'b1;
                            if (cp_ovf) begin
                                status_next = eilp_pkg::STAT_OVERFLOW;
                            end
                        end else if (!seen_reg) begin
                            status_next = eilp_pkg::STAT_BAD_CP;
                        end else begin
                            // The terminating byte is looked at again as a comment byte.
                            entry_next = 1'b1;
                            state_next = eilp_pkg::PS_IGNORE;
                            exam_state = eilp_pkg::PS_IGNORE;
                            examine    = 1'b1;
                        end
                    end
                    default: begin
                        examine = 1'b1;
                    end
                endcase

                if (examine) begin
                    unique case (exam_state)
                        eilp_pkg::PS_IGNORE: begin
                            if (b == eilp_pkg::CHAR_LF) begin
                                state_next = eilp_pkg::PS_LINE_START;
                            end
                        end
                        eilp_pkg::PS_BEFORE_INDEX: begin
                            if (eilp_pkg::is_blank(b)) begin
                                state_next = exam_state;
                            end else if (eilp_pkg::is_dec(b)) begin
                                ptr_next   = PB'(b[3:0]);
                                seen_next  = 1'b1;
                                state_next = eilp_pkg::PS_POINTER;
                            end else begin
                                status_next = eilp_pkg::STAT_BAD_BEFORE_I;
                            end
                        end
                        eilp_pkg::PS_BEFORE_CP: begin
                            if (eilp_pkg::is_blank(b) || b == eilp_pkg::CHAR_ZERO) begin
                                state_next = exam_state;
                            end else if (b == eilp_pkg::CHAR_X) begin
                                cp_next    = '0;
                                seen_next  = 1'b0;
                                state_next = eilp_pkg::PS_CODEPOINT;
                            end else begin
                                status_next = eilp_pkg::STAT_BAD_BEFORE_C;
                            end
                        end
                        default: begin
                            state_next = eilp_pkg::PS_LINE_START;
                            if (b == eilp_pkg::CHAR_HASH) begin
                                state_next = eilp_pkg::PS_IGNORE;
                            end else if (b == eilp_pkg::CHAR_LF) begin
                                state_next = eilp_pkg::PS_LINE_START;
                            end else if (eilp_pkg::is_blank(b)) begin
                                state_next = eilp_pkg::PS_BEFORE_INDEX;
                            end else if (eilp_pkg::is_dec(b)) begin
                                ptr_next   = PB'(b[3:0]);
                                seen_next  = 1'b1;
                                state_next = eilp_pkg::PS_POINTER;
                            end else begin
                                status_next = eilp_pkg::STAT_BAD_START;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Result payload: the pair is only shown on a beat that completes an entry.
    always_comb begin
        ptr_ext    = PW_EXT'(ptr_reg);
        cp_ext     = CW_EXT'(cp_reg);
        m_ptr_next = entry_next ? ptr_ext[POB-1:0] : '0;
        m_cp_next  = entry_next ? cp_ext[COB-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= eilp_pkg::PS_LINE_START;
            status_reg  <= eilp_pkg::STAT_PARSING;
            ptr_reg     <= '0;
            cp_reg      <= '0;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg   <= state_next;
                status_reg  <= status_next;
                ptr_reg     <= ptr_next;
                cp_reg      <= cp_next;
                seen_reg    <= seen_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_entry_reg  <= entry_next;
            m_ptr_reg    <= m_ptr_next;
            m_cp_reg     <= m_cp_next;
            m_status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_entry_reg;
    assign m_tdata  = {{PAD_BITS{1'b0}}, m_status_reg, m_cp_reg, m_ptr_reg};

    `EILP_ASSERT_NOW(a_entry_only_while_parsing, aclk, aresetn,
        m_valid_reg && m_entry_reg, m_status_reg == eilp_pkg::STAT_PARSING)

    `EILP_ASSERT_NEXT(a_status_sticks, aclk, aresetn,
        status_reg != eilp_pkg::STAT_PARSING, status_reg == $past(status_reg))

    `EILP_ASSERT_NEXT(a_end_sets_final_status, aclk, aresetn,
        accept && s_tlast && status_reg == eilp_pkg::STAT_PARSING,
        m_status_reg == eilp_pkg::STAT_DONE || m_status_reg == eilp_pkg::STAT_MALFORMED)

endmodule
